// ===== hdl/csrb_pkg.sv =====
// constants, codes and request types shared by the sparse row builder files
`default_nettype none

package csrb_pkg;

  localparam int unsigned MaxRows    = 256;
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned EntW  = $clog2(MaxEntries);
  localparam int unsigned CntW  = EntW + 1;
  localparam int unsigned NRowW = RowW + 1;
  localparam int unsigned ColW  = 16;
  localparam int unsigned ValW  = 64;
  localparam int unsigned OpW   = 2;
  localparam int unsigned StatW = 3;

  // operation codes
  localparam logic [OpW-1:0] OpAdd      = 2'd0;
  localparam logic [OpW-1:0] OpRowQuery = 2'd1;
  localparam logic [OpW-1:0] OpReadEnt  = 2'd2;

  // status codes
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StRange    = 3'd1;
  localparam logic [StatW-1:0] StClosed   = 3'd2;
  localparam logic [StatW-1:0] StSkipped  = 3'd3;
  localparam logic [StatW-1:0] StColOrder = 3'd4;
  localparam logic [StatW-1:0] StFull     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CfgNumRows  = 2'd0;
  localparam logic [1:0] CfgCapacity = 2'd1;

  typedef struct packed {
    logic            row_we;
    logic [RowW-1:0] row_waddr;
    logic [EntW-1:0] row_wdata;
    logic            ent_we;
    logic [EntW-1:0] ent_waddr;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
  } store_wr_t;

  typedef struct packed {
    logic            re;
    logic [RowW-1:0] row_addr_a;
    logic [RowW-1:0] row_addr_b;
    logic [EntW-1:0] ent_addr;
  } store_rd_t;

  typedef struct packed {
    logic [EntW-1:0] row_start_a;
    logic [EntW-1:0] row_start_b;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
  } store_rdata_t;

endpackage

`default_nettype wire

// ===== hdl/csr_sparse_row_builder.sv =====
// top level of the compressed sparse row matrix builder
//
// requests arrive on s_axis: s_axis_tuser carries the op (0 add element, 1 row
// query, 2 entry read), s_axis_tdata the row, column, value and entry index.
// every request gives exactly one response on m_axis, in request order.
// configuration goes through the cfg channel (index 0 rows in use, index 1
// entry capacity); cfg_ready_o is always high, writes belong to idle time.
// an add is checked and written to memory at the accept edge, where the
// memories also register their read data; the response register is loaded
// from that read data as soon as it is free.
// a request is only taken when no earlier one is still waiting on memory
// read data, so memory accesses of consecutive requests never overlap; a new
// request is not taken before the last one has left the read stage.
// m_axis_tvalid is driven straight from the response register.
// if m_axis stalls, the response register holds; one further request is
// taken and parks in the read stage until the response register frees up.
// reset clears the row valid flags, the entry count and the last column,
// and restores the registers to 256 rows and 1024 entries; no clearing
// pass is needed, read data from beyond the entry count is never used.
`default_nettype none

module csr_sparse_row_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [10:0]  cfg_data_i,
  // request channel
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row_index[7:0], column_index[23:8], value_bits[87:24], entry_index[97:88], zero pad
  input  logic [103:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]   s_axis_tuser,
  // response channel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], row_started[3], row_start[13:4], row_length[24:14],
  // column_out[40:25], value_out[104:41], zero pad
  output logic [111:0] m_axis_tdata
);

  localparam int unsigned RowW  = csrb_pkg::RowW;
  localparam int unsigned EntW  = csrb_pkg::EntW;
  localparam int unsigned CntW  = csrb_pkg::CntW;
  localparam int unsigned NRowW = csrb_pkg::NRowW;
  localparam int unsigned ColW  = csrb_pkg::ColW;
  localparam int unsigned ValW  = csrb_pkg::ValW;
  localparam int unsigned OpW   = csrb_pkg::OpW;
  localparam int unsigned StatW = csrb_pkg::StatW;

  localparam logic [NRowW-1:0] RowsLim = NRowW'(csrb_pkg::MaxRows);
  localparam logic [CntW-1:0]  EntLim  = CntW'(csrb_pkg::MaxEntries);

  // configuration registers
  logic [NRowW-1:0] num_rows_q;
  logic [CntW-1:0]  capacity_q;

  // builder state held in flops
  logic [csrb_pkg::MaxRows-1:0] row_valid_q;
  logic [CntW-1:0]              entries_q;
  logic [ColW-1:0]              last_col_q;

  // read stage: request waiting on memory data
  logic             busy_q;
  logic [OpW-1:0]   op_q;
  logic [RowW-1:0]  row_q;
  logic [EntW-1:0]  ent_q;
  logic [StatW-1:0] add_stat_q;

  // response register
  logic             out_valid_q;
  logic [StatW-1:0] out_stat_q;
  logic             out_started_q;
  logic [EntW-1:0]  out_start_q;
  logic [CntW-1:0]  out_len_q;
  logic [ColW-1:0]  out_col_q;
  logic [ValW-1:0]  out_val_q;

  // request fields
  logic [OpW-1:0]  in_op;
  logic [RowW-1:0] in_row;
  logic [ColW-1:0] in_col;
  logic [ValW-1:0] in_val;
  logic [EntW-1:0] in_ent;

  assign in_op  = s_axis_tuser;
  assign in_row = s_axis_tdata[7:0];
  assign in_col = s_axis_tdata[23:8];
  assign in_val = s_axis_tdata[87:24];
  assign in_ent = s_axis_tdata[97:88];

  logic s_acc;
  logic out_free;
  logic done;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign done          = busy_q && out_free;
  assign s_axis_tready = !busy_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // saturated register values
  logic [NRowW-1:0] nrows_sat;
  logic [CntW-1:0]  cap_sat;

  assign nrows_sat = (num_rows_q > RowsLim) ? RowsLim : num_rows_q;
  assign cap_sat   = (capacity_q > EntLim) ? EntLim : capacity_q;

  // add checks, from state flops and request fields, settled by the accept edge
  logic [NRowW-1:0] a_row_ext;
  logic [NRowW-1:0] a_row_nx;
  logic [RowW-1:0]  a_row_pv;
  logic             a_started;
  logic             a_nx_started;
  logic [StatW-1:0] a_stat;

  assign a_row_ext    = {1'b0, in_row};
  assign a_row_nx     = a_row_ext + NRowW'(1);
  assign a_row_pv     = in_row - RowW'(1);
  assign a_started    = row_valid_q[in_row];
  assign a_nx_started = (a_row_nx < nrows_sat) && row_valid_q[a_row_nx[RowW-1:0]];

  always_comb begin
    if (a_row_ext >= nrows_sat) begin
      a_stat = csrb_pkg::StRange;
    end else if (a_started && a_nx_started) begin
      a_stat = csrb_pkg::StClosed;
    end else if (!a_started && (in_row != '0) && !row_valid_q[a_row_pv]) begin
      a_stat = csrb_pkg::StSkipped;
    end else if (a_started && (entries_q != '0) && (last_col_q >= in_col)) begin
      // a started row always has at least one stored entry
      a_stat = csrb_pkg::StColOrder;
    end else if (entries_q >= cap_sat) begin
      a_stat = csrb_pkg::StFull;
    end else begin
      a_stat = csrb_pkg::StOk;
    end
  end

  logic add_ok;
  assign add_ok = s_acc && (in_op == csrb_pkg::OpAdd) && (a_stat == csrb_pkg::StOk);

  // memory requests
  csrb_pkg::store_wr_t    st_wr;
  csrb_pkg::store_rd_t    st_rd;
  csrb_pkg::store_rdata_t st_rdata;

  always_comb begin
    st_wr.row_we     = add_ok && !a_started;
    st_wr.row_waddr  = in_row;
    st_wr.row_wdata  = entries_q[EntW-1:0];
    st_wr.ent_we     = add_ok;
    st_wr.ent_waddr  = entries_q[EntW-1:0];
    st_wr.col        = in_col;
    st_wr.val        = in_val;
    st_rd.re         = s_acc;
    st_rd.row_addr_a = in_row;
    st_rd.row_addr_b = a_row_nx[RowW-1:0];
    st_rd.ent_addr   = in_ent;
  end

  csrb_store u_store (
    .clk_i   (clk_i),
    .wr_i    (st_wr),
    .rd_i    (st_rd),
    .rdata_o (st_rdata)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RowsLim;
      capacity_q <= EntLim;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csrb_pkg::CfgNumRows:  num_rows_q <= cfg_data_i[NRowW-1:0];
        csrb_pkg::CfgCapacity: capacity_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // builder state update on an accepted add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      entries_q   <= '0;
      last_col_q  <= '0;
    end else if (add_ok) begin
      row_valid_q[in_row] <= 1'b1;
      entries_q           <= entries_q + CntW'(1);
      last_col_q          <= in_col;
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (s_acc) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q       <= in_op;
      row_q      <= in_row;
      ent_q      <= in_ent;
      add_stat_q <= a_stat;
    end
  end

  // response build from the read data; state is unchanged since the accept
  logic [NRowW-1:0] q_row_ext;
  logic [NRowW-1:0] q_row_nx;
  logic             q_nx_started;
  logic [CntW-1:0]  q_start;
  logic [CntW-1:0]  q_end;

  assign q_row_ext    = {1'b0, row_q};
  assign q_row_nx     = q_row_ext + NRowW'(1);
  assign q_nx_started = (q_row_nx < nrows_sat) && row_valid_q[q_row_nx[RowW-1:0]];
  assign q_start      = {1'b0, st_rdata.row_start_a};
  assign q_end        = q_nx_started ? {1'b0, st_rdata.row_start_b} : entries_q;

  logic [StatW-1:0] r_stat;
  logic             r_started;
  logic [EntW-1:0]  r_start;
  logic [CntW-1:0]  r_len;
  logic [ColW-1:0]  r_col;
  logic [ValW-1:0]  r_val;

  always_comb begin
    r_stat    = csrb_pkg::StOk;
    r_started = 1'b0;
    r_start   = '0;
    r_len     = '0;
    r_col     = '0;
    r_val     = '0;
    case (op_q)
      csrb_pkg::OpAdd: begin
        r_stat = add_stat_q;
      end
      csrb_pkg::OpRowQuery: begin
        if (q_row_ext >= nrows_sat) begin
          r_stat = csrb_pkg::StRange;
        end else if (row_valid_q[row_q]) begin
          r_started = 1'b1;
          r_start   = st_rdata.row_start_a;
          r_len     = (q_end >= q_start) ? (q_end - q_start) : '0;
        end
      end
      csrb_pkg::OpReadEnt: begin
        if ({1'b0, ent_q} >= entries_q) begin
          r_stat = csrb_pkg::StRange;
        end else begin
          r_col = st_rdata.col;
          r_val = st_rdata.val;
        end
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_stat_q    <= r_stat;
      out_started_q <= r_started;
      out_start_q   <= r_start;
      out_len_q     <= r_len;
      out_col_q     <= r_col;
      out_val_q     <= r_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_val_q, out_col_q, out_len_q, out_start_q,
                          out_started_q, out_stat_q};

  // the first entry ever stored must belong to row 0
  a_row0_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entries_q != '0) |-> row_valid_q[0])
    else $error("entries stored but row 0 not started");

  // an accepted add that passes all checks grows the entry count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> (entries_q == $past(entries_q) + CntW'(1)))
    else $error("entry count did not advance on add");

  // the count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= EntLim)
    else $error("entry count beyond store depth");

  // memory accesses of two requests never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (busy_q && !s_acc))
    else $error("request accepted while previous one awaits read data");

  // a waiting response is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_stat_q)))
    else $error("stalled response changed");

endmodule

`default_nettype wire

// ===== hdl/csrb_store.sv =====
// row start memory and entry memory, registered reads
`default_nettype none

module csrb_store (
  input  logic                  clk_i,
  input  csrb_pkg::store_wr_t   wr_i,
  input  csrb_pkg::store_rd_t   rd_i,
  output csrb_pkg::store_rdata_t rdata_o
);

  logic [csrb_pkg::EntW-1:0] row_mem [csrb_pkg::MaxRows];
  logic [csrb_pkg::ColW-1:0] col_mem [csrb_pkg::MaxEntries];
  logic [csrb_pkg::ValW-1:0] val_mem [csrb_pkg::MaxEntries];

  // row start memory: one write port, two read ports
  // entry memory: column and value side by side
  always_ff @(posedge clk_i) begin
    if (wr_i.row_we) begin
      row_mem[wr_i.row_waddr] <= wr_i.row_wdata;
    end
    if (wr_i.ent_we) begin
      col_mem[wr_i.ent_waddr] <= wr_i.col;
      val_mem[wr_i.ent_waddr] <= wr_i.val;
    end
    if (rd_i.re) begin
      rdata_o.row_start_a <= row_mem[rd_i.row_addr_a];
      rdata_o.row_start_b <= row_mem[rd_i.row_addr_b];
      rdata_o.col         <= col_mem[rd_i.ent_addr];
      rdata_o.val         <= val_mem[rd_i.ent_addr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the compressed sparse row matrix builder
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

  // widths and codes taken from the shared package
  localparam int unsigned OpW        = csrb_pkg::OpW;
  localparam int unsigned RowW       = csrb_pkg::RowW;
  localparam int unsigned ColW       = csrb_pkg::ColW;
  localparam int unsigned ValW       = csrb_pkg::ValW;
  localparam int unsigned EntW       = csrb_pkg::EntW;
  localparam int unsigned CntW       = csrb_pkg::CntW;
  localparam int unsigned StatW      = csrb_pkg::StatW;
  localparam int unsigned MaxRows    = csrb_pkg::MaxRows;
  localparam int unsigned MaxEntries = csrb_pkg::MaxEntries;

  localparam logic [OpW-1:0] OpAdd      = csrb_pkg::OpAdd;
  localparam logic [OpW-1:0] OpRowQuery = csrb_pkg::OpRowQuery;
  localparam logic [OpW-1:0] OpReadEnt  = csrb_pkg::OpReadEnt;

  localparam logic [StatW-1:0] StOk       = csrb_pkg::StOk;
  localparam logic [StatW-1:0] StRange    = csrb_pkg::StRange;
  localparam logic [StatW-1:0] StClosed   = csrb_pkg::StClosed;
  localparam logic [StatW-1:0] StSkipped  = csrb_pkg::StSkipped;
  localparam logic [StatW-1:0] StColOrder = csrb_pkg::StColOrder;
  localparam logic [StatW-1:0] StFull     = csrb_pkg::StFull;

  localparam logic [1:0] CfgNumRows  = csrb_pkg::CfgNumRows;
  localparam logic [1:0] CfgCapacity = csrb_pkg::CfgCapacity;

  // op code the block answers with an all-zero response
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // request fields as packed on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [EntW-1:0] ent;
    logic [ValW-1:0] val;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } req_t;

  // response fields as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [ValW-1:0]  val;
    logic [ColW-1:0]  col;
    logic [CntW-1:0]  len;
    logic [EntW-1:0]  start;
    logic             started;
    logic [StatW-1:0] status;
  } rsp_t;

  // one row of the directed stimulus table
  typedef struct {
    logic [OpW-1:0]   op;
    req_t             rq;
    bit               typed;
    logic [StatW-1:0] st;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [10:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  csr_sparse_row_builder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // matrix shadow: row starts, entry store, entry count and register copies
  // ---------------------------------------------------------------------------
  logic [EntW-1:0] row_start_q [MaxRows];
  bit              row_used    [MaxRows];
  logic [ColW-1:0] col_mem     [MaxEntries];
  logic [ValW-1:0] val_mem     [MaxEntries];
  int unsigned     n_stored;
  int unsigned     rows_cfg;
  int unsigned     cap_cfg;
  int              top_row;     // highest started row, rows start contiguously
  int unsigned     add_seen [8];

  rsp_t rsp_due [$];            // responses still owed by the block
  int   n_mismatch;
  int   n_fail;
  int   n_sent;
  int   n_adds;
  bit   hold_rsp_req;

  function automatic int unsigned rows_live();
    return (rows_cfg > MaxRows) ? MaxRows : rows_cfg;
  endfunction

  function automatic int unsigned cap_live();
    return (cap_cfg > MaxEntries) ? MaxEntries : cap_cfg;
  endfunction

  // append checks in priority order, store only when all pass
  function automatic logic [StatW-1:0] try_append(input int row, input int unsigned col,
                                                  input logic [ValW-1:0] val);
    int unsigned nrows;
    bit          started;
    nrows = rows_live();
    if (row >= nrows) return StRange;
    started = row_used[row];
    if (started && row + 1 < nrows && row_used[row+1]) return StClosed;
    if (!started && row != 0 && !row_used[row-1]) return StSkipped;
    // order is judged against the last entry stored anywhere
    if (started && n_stored > 0 && col_mem[n_stored-1] >= col) return StColOrder;
    if (n_stored >= cap_live()) return StFull;
    col_mem[n_stored] = ColW'(col);
    val_mem[n_stored] = val;
    if (!started) begin
      row_start_q[row] = EntW'(n_stored);
      row_used[row]    = 1'b1;
      if (row > top_row) top_row = row;
    end
    n_stored++;
    return StOk;
  endfunction

  function automatic rsp_t csr_response(input logic [OpW-1:0] op, input req_t rq);
    rsp_t        r;
    int unsigned nrows;
    int          row;
    int unsigned stop_pos;
    r     = '0;
    row   = int'(rq.row);
    nrows = rows_live();
    case (op)
      OpAdd: begin
        r.status = try_append(row, 32'(rq.col), rq.val);
        add_seen[r.status]++;
      end
      OpRowQuery: begin
        if (row >= nrows) begin
          r.status = StRange;
        end else if (row_used[row]) begin
          r.started = 1'b1;
          r.start   = row_start_q[row];
          // length runs to the next row start, else to the end of the store
          if (row + 1 < nrows && row_used[row+1]) stop_pos = 32'(row_start_q[row+1]);
          else stop_pos = n_stored;
          r.len = (stop_pos >= r.start) ? CntW'(stop_pos - r.start) : '0;
        end
      end
      OpReadEnt: begin
        if (rq.ent >= n_stored) begin
          r.status = StRange;
        end else begin
          r.col = col_mem[rq.ent];
          r.val = val_mem[rq.ent];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic issue(input logic [OpW-1:0] op, input req_t rq, input bit typed,
                       input logic [StatW-1:0] typed_st);
    int   gap;
    rsp_t r;
    // every third stretch of 40 requests runs back to back
    gap = ((n_sent / 40) % 3 == 1) ? 0 : int'($urandom_range(0, 15));
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(104 - $bits(req_t)){1'b0}}, rq};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    r = csr_response(op, rq);
    if (typed) begin
      r        = '0;
      r.status = typed_st;
    end
    rsp_due.push_back(r);
    n_sent++;
    if (op == OpAdd) n_adds++;
  endtask

  // waits until every response is in and the block has settled
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(input int unsigned rows, input int unsigned cap);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgNumRows;
    cfg_data_i  <= rows[10:0];
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    rows_cfg = rows & 32'h1FF;
    @(negedge clk_i);
    cfg_index_i <= CfgCapacity;
    cfg_data_i  <= cap[10:0];
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cap_cfg = cap & 32'h7FF;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed row building at the frontier, plus noise
  task automatic run_random(input int count);
    int             done;
    int             pick;
    int             row;
    int unsigned    nrows;
    int unsigned    last_col;
    int unsigned    col;
    int unsigned    lo;
    int unsigned    hi;
    bit             grow;
    logic [OpW-1:0] op;
    req_t           rq;
    done = 0;
    while (done < count) begin
      pick   = int'($urandom_range(0, 99));
      rq.row = RowW'($urandom_range(0, 255));
      rq.col = ColW'($urandom_range(0, 16'hFFFF));
      rq.val = {$urandom, $urandom};
      rq.ent = EntW'($urandom_range(0, 1023));
      nrows  = rows_live();
      if (pick < 45) begin
        op = OpAdd;
        if ($urandom_range(0, 9) < 7) begin
          if (top_row < 0) begin
            rq.row = '0;
          end else begin
            last_col = 32'(col_mem[n_stored-1]);
            grow = ($urandom_range(0, 2) == 0) || (last_col == 16'hFFFF);
            if (grow && top_row < 255 && top_row + 1 < nrows) begin
              rq.row = RowW'(top_row + 1);
              if ($urandom_range(0, 1) == 0) rq.col = ColW'($urandom_range(0, 255));
            end else begin
              // keep extending the newest row still in use
              row    = (top_row < nrows) ? top_row : int'(nrows - 1);
              rq.row = RowW'(row);
              col    = last_col + 1 + $urandom_range(0, 15);
              rq.col = (col > 16'hFFFF) ? 16'hFFFF : ColW'(col);
            end
          end
        end
      end else if (pick < 70) begin
        op = OpRowQuery;
        if ($urandom_range(0, 1) == 0 && top_row >= 0) begin
          lo     = (top_row > 3) ? top_row - 3 : 0;
          hi     = (top_row + 1 > 255) ? 255 : top_row + 1;
          rq.row = RowW'($urandom_range(lo, hi));
        end
      end else if (pick < 95) begin
        op = OpReadEnt;
        if ($urandom_range(0, 9) < 7) begin
          hi     = (n_stored > 1023) ? 1023 : n_stored;
          rq.ent = EntW'($urandom_range(0, hi));
        end
      end else begin
        op = OpUnused;
      end
      issue(op, rq, 1'b0, StOk);
      if (op != OpUnused) done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rsp_ready_gen
    int stall;
    int n_taken;
    n_taken = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end
      stall = ((n_taken / 56) % 3 == 2) ? 0 : int'($urandom_range(0, 15));
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      n_taken++;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_t act;
    rsp_t want;
    bit   bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata[$bits(rsp_t)-1:0];
      if (rsp_due.size() == 0) begin
        n_fail++;
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: response with none outstanding: st=%0d col=%h val=%h",
                   $realtime, act.status, act.col, act.val);
      end else begin
        want = rsp_due.pop_front();
        bad  = (act.status !== want.status) || (act.started !== want.started) ||
               (act.start !== want.start) || (act.len !== want.len) ||
               (act.col !== want.col) || (act.val !== want.val);
        if (bad) begin
          n_fail++;
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: mismatch exp st=%0d rs=%0d start=%0d len=%0d col=%h val=%h",
                     $realtime, want.status, want.started, want.start, want.len,
                     want.col, want.val);
            $display("%0t:          got st=%0d rs=%0d start=%0d len=%0d col=%h val=%h",
                     $realtime, act.status, act.started, act.start, act.len,
                     act.col, act.val);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [$];

  function automatic void dir_add(input logic [OpW-1:0] op, input int row,
                                  input int unsigned col, input logic [ValW-1:0] val,
                                  input int ent, input bit typed,
                                  input logic [StatW-1:0] st);
    dir_row_t d;
    d.op     = op;
    d.rq.row = RowW'(row);
    d.rq.col = ColW'(col);
    d.rq.val = val;
    d.rq.ent = EntW'(ent);
    d.typed  = typed;
    d.st     = st;
    dir_tab.push_back(d);
  endfunction

  initial begin : main
    int unsigned rows_sel;
    int unsigned cap_sel;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_rsp_req  = 1'b0;
    n_mismatch    = 0;
    n_fail        = 0;
    n_sent        = 0;
    n_adds        = 0;
    n_stored      = 0;
    top_row       = -1;
    rows_cfg      = 256;
    cap_cfg       = 1024;
    foreach (row_used[i]) begin
      row_used[i]    = 1'b0;
      row_start_q[i] = '0;
    end
    foreach (add_seen[i]) add_seen[i] = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty matrix, reset registers
    dir_add(OpRowQuery, 0, 0, 64'd0, 0, 1, StOk);            // unstarted row
    dir_add(OpReadEnt, 0, 0, 64'd0, 0, 1, StRange);          // empty store
    dir_add(OpAdd, 1, 0, 64'd0, 0, 1, StSkipped);            // row 0 not begun
    dir_add(OpAdd, 255, 16'hFFFF, '1, 1023, 1, StSkipped);
    dir_add(OpAdd, 0, 5, 64'd0, 0, 1, StOk);
    dir_add(OpAdd, 0, 5, 64'd1, 0, 1, StColOrder);           // repeated column
    dir_add(OpAdd, 0, 4, 64'd1, 0, 1, StColOrder);           // falling column
    dir_add(OpAdd, 0, 16'hFFFF, '1, 0, 1, StOk);
    dir_add(OpAdd, 1, 0, 64'h5555_5555_5555_5555, 0, 1, StOk);
    dir_add(OpAdd, 0, 0, 64'd0, 0, 1, StClosed);             // closed beats order
    dir_add(OpAdd, 1, 0, 64'd0, 0, 1, StColOrder);
    dir_add(OpAdd, 1, 16'hFFFF, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1, StOk);
    dir_add(OpAdd, 3, 1, 64'd0, 0, 1, StSkipped);
    dir_add(OpRowQuery, 0, 0, 64'd0, 0, 0, StOk);
    dir_add(OpRowQuery, 1, 0, 64'd0, 0, 0, StOk);            // open last row
    dir_add(OpRowQuery, 255, 0, 64'd0, 0, 1, StOk);
    dir_add(OpReadEnt, 0, 0, 64'd0, 0, 0, StOk);
    dir_add(OpReadEnt, 0, 0, 64'd0, 1, 0, StOk);
    dir_add(OpReadEnt, 0, 0, 64'd0, 3, 0, StOk);
    dir_add(OpReadEnt, 0, 0, 64'd0, 4, 1, StRange);          // one past the end
    dir_add(OpReadEnt, 0, 0, 64'd0, 1023, 1, StRange);
    dir_add(OpUnused, 255, 16'hFFFF, '1, 1023, 1, StOk);     // unused op, zeros
    dir_add(OpAdd, 2, 0, 64'd0, 0, 1, StOk);
    dir_add(OpRowQuery, 1, 0, 64'd0, 0, 0, StOk);            // now bounded by row 2
    dir_add(OpRowQuery, 2, 0, 64'd0, 0, 0, StOk);
    foreach (dir_tab[i]) issue(dir_tab[i].op, dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].st);

    // single row in use: every other row is out of range, row 0 never closes
    set_regs(1, 1024);
    run_random(60);

    // full size, with the response side held off for a while
    set_regs(256, 1024);
    hold_rsp_req = 1'b1;
    run_random(380);

    // newest row is the last in use and the store fills up shortly
    rows_sel = (top_row + 1 > 256) ? 256 : top_row + 1;
    cap_sel  = (n_stored + 12 > 1024) ? 1024 : n_stored + 12;
    set_regs(rows_sel, cap_sel);
    run_random(200);

    // smallest capacity, always full
    set_regs(256, 1);
    run_random(60);

    // mid-size row count, full capacity, another long hold-off
    rows_sel = (top_row + 2 > 256) ? 256 : top_row + 2;
    set_regs($urandom_range(rows_sel, 256), 1024);
    hold_rsp_req = 1'b1;
    run_random(530);

    drain();
    repeat (8) @(posedge clk_i);
    n_fail += rsp_due.size();

    $display("summary: %0d requests, %0d adds; %0d entries stored over %0d rows",
             n_sent, n_adds, n_stored, top_row + 1);
    $display("summary: adds ok %0d range %0d closed %0d skipped %0d order %0d full %0d",
             add_seen[StOk], add_seen[StRange], add_seen[StClosed], add_seen[StSkipped],
             add_seen[StColOrder], add_seen[StFull]);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
